@@ hw/rtl/pseq_pkg.sv @@
// pseq_pkg: shared types and constants for the power sequencer
// item and result structs, queue job record, spi command codes, register indexes
// no dependencies

package pseq_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam logic [9:0]  AC_THR_RESET   = 10'd530;
  localparam logic [9:0]  BATT_THR_RESET = 10'd300;
  localparam logic [7:0]  HOLD_RESET     = 8'd51;
  localparam logic [11:0] SHDN_RESET     = 12'd850;
  localparam logic [7:0]  DUTY_RESET     = 8'd128;
  localparam logic [7:0]  HOLD_SAT       = 8'd255;
  localparam logic [7:0]  REPLY_MARK     = 8'hA8;
  localparam logic [7:0]  STATUS_IRQ     = 8'h40;
  localparam logic [7:0]  STATUS_NO_IRQ  = 8'h45;
  localparam logic [1:0]  TRIPLE_LAST    = 2'd2;
  localparam logic [1:0]  TRIPLE_MID     = 2'd1;

  localparam logic [7:0] CMD_SET_DUTY  = 8'h40;
  localparam logic [7:0] CMD_READ_AC   = 8'h41;
  localparam logic [7:0] CMD_READ_BATT = 8'h42;
  localparam logic [7:0] CMD_SHUTDOWN  = 8'h43;
  localparam logic [7:0] CMD_PANEL_OFF = 8'h44;
  localparam logic [7:0] CMD_STATUS    = 8'h45;

  typedef enum logic [1:0] {
    REG_AC_THR   = 2'd0,
    REG_BATT_THR = 2'd1,
    REG_HOLD     = 2'd2,
    REG_SHDN     = 2'd3
  } reg_index_t;

  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_SPI  = 1'b1
  } action_t;

  typedef struct packed {
    logic                   action;
    logic                   button;
    logic [SAMPLE_BITS-1:0] ac_level;
    logic [SAMPLE_BITS-1:0] batt_level;
    logic [7:0]             spi_byte;
  } item_t;

  typedef struct packed {
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       last;
    logic [7:0] pwm_duty;
    logic       host_power;
    logic       panel_on;
    logic       battery_select;
    logic       red_led;
    logic       green_led;
    logic       irq_pulse;
  } result_t;

  typedef struct packed {
    logic [7:0] pwm_duty;
    logic       host_power;
    logic       panel_on;
    logic       battery_select;
    logic       red_led;
    logic       green_led;
    logic       irq_pulse;
  } status_t;

  typedef enum logic [1:0] {
    JOB_PLAIN  = 2'd0,
    JOB_REPLY  = 2'd1,
    JOB_TRIPLE = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] byte_hi;
    logic [7:0] byte_lo;
    status_t    status;
  } job_t;

endpackage

@@ hw/rtl/pseq_front.sv @@
// pseq_front: accepts items, holds the sequencer state and config registers,
// and turns each item into one job record for the queue
// depends on pseq_pkg

module pseq_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [1:0]            wr_index,
  input  logic [11:0]           wr_data,
  input  logic                  accept,
  input  pseq_pkg::item_t       item,
  output pseq_pkg::job_t        job
);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HOLD    = 2'd1,
    PH_RELEASE = 2'd2
  } phase_t;

  logic [9:0]  ac_threshold;
  logic [9:0]  batt_threshold;
  logic [7:0]  hold_ticks;
  logic [11:0] shutdown_ticks;

  logic        powered, powered_next;
  logic        panel_state, panel_state_next;
  logic        ac_ok, ac_ok_next;
  logic        batt_ok, batt_ok_next;
  logic [pseq_pkg::SAMPLE_BITS-1:0] ac_sample, ac_sample_next;
  logic [pseq_pkg::SAMPLE_BITS-1:0] batt_sample, batt_sample_next;
  phase_t      press_phase, press_phase_next;
  logic [7:0]  hold_count, hold_count_next;
  logic [11:0] shutdown_count, shutdown_count_next;
  logic [7:0]  duty, duty_next;
  logic        irq_seen, irq_seen_next;
  logic        expect_duty, expect_duty_next;
  logic        red, red_next;
  logic        green, green_next;

  logic        irq;
  logic        finish;
  logic        busy;
  logic [pseq_pkg::SAMPLE_BITS-1:0] sel_sample;

  always_comb begin
    powered_next        = powered;
    panel_state_next    = panel_state;
    ac_ok_next          = ac_ok;
    batt_ok_next        = batt_ok;
    ac_sample_next      = ac_sample;
    batt_sample_next    = batt_sample;
    press_phase_next    = press_phase;
    hold_count_next     = hold_count;
    shutdown_count_next = shutdown_count;
    duty_next           = duty;
    irq_seen_next       = irq_seen;
    expect_duty_next    = expect_duty;
    red_next            = red;
    green_next          = green;
    irq                 = 1'b0;
    finish              = 1'b0;
    busy                = (shutdown_count != '0) || (press_phase != PH_IDLE);
    sel_sample          = (item.spi_byte == pseq_pkg::CMD_READ_AC) ? ac_sample : batt_sample;
    job.kind            = pseq_pkg::JOB_PLAIN;
    job.byte_hi         = 8'(sel_sample >> 8) | pseq_pkg::REPLY_MARK;
    job.byte_lo         = sel_sample[7:0];

    if (item.action == pseq_pkg::ACT_TICK) begin
      if (shutdown_count != '0) begin
        shutdown_count_next = shutdown_count - 12'd1;
        finish = (shutdown_count == 12'd1);
      end else if (press_phase == PH_HOLD) begin
        if (!item.button) begin
          press_phase_next = PH_IDLE;
        end else begin
          hold_count_next = (hold_count < pseq_pkg::HOLD_SAT) ? hold_count + 8'd1 : hold_count;
          if (hold_count_next >= hold_ticks) begin
            powered_next     = 1'b1;
            panel_state_next = 1'b1;
            red_next         = 1'b0;
            green_next       = 1'b1;
            press_phase_next = PH_RELEASE;
          end
        end
      end else if (!(press_phase == PH_RELEASE && item.button)) begin
        // release seen: drop a rejected-press red unless powered
        if (press_phase == PH_RELEASE && !powered) red_next = 1'b0;
        press_phase_next = PH_IDLE;
        ac_sample_next   = item.ac_level;
        batt_sample_next = item.batt_level;
        ac_ok_next       = item.ac_level >= ac_threshold;
        batt_ok_next     = item.batt_level >= batt_threshold;
        if (item.button) begin
          if (powered) begin
            if (panel_state) begin
              panel_state_next = 1'b0;
              irq_seen_next    = 1'b1;
              irq              = 1'b1;
              red_next         = 1'b1;
            end else begin
              panel_state_next = 1'b1;
              red_next         = 1'b0;
            end
            press_phase_next = PH_RELEASE;
          end else if (ac_ok_next || batt_ok_next) begin
            hold_count_next  = '0;
            press_phase_next = PH_HOLD;
          end else begin
            red_next         = 1'b1;
            green_next       = 1'b0;
            press_phase_next = PH_RELEASE;
          end
        end
      end
    end else if (!busy) begin
      if (expect_duty) begin
        duty_next        = item.spi_byte;
        expect_duty_next = 1'b0;
      end else begin
        case (item.spi_byte)
          pseq_pkg::CMD_READ_AC, pseq_pkg::CMD_READ_BATT: begin
            job.kind = pseq_pkg::JOB_TRIPLE;
          end
          pseq_pkg::CMD_STATUS: begin
            job.kind    = pseq_pkg::JOB_REPLY;
            job.byte_hi = irq_seen ? pseq_pkg::STATUS_IRQ : pseq_pkg::STATUS_NO_IRQ;
          end
          pseq_pkg::CMD_SET_DUTY: begin
            expect_duty_next = 1'b1;
          end
          pseq_pkg::CMD_SHUTDOWN: begin
            powered_next        = 1'b0;
            red_next            = 1'b1;
            shutdown_count_next = shutdown_ticks;
            finish              = (shutdown_ticks == '0);
          end
          pseq_pkg::CMD_PANEL_OFF: begin
            panel_state_next = 1'b0;
            irq_seen_next    = 1'b1;
            irq              = 1'b1;
            if (powered) red_next = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end

    // end of the shutdown countdown, or at once when the shutdown count is zero
    if (finish) begin
      if (panel_state_next) begin
        panel_state_next = 1'b0;
        irq_seen_next    = 1'b1;
        irq              = 1'b1;
      end
      powered_next        = 1'b0;
      red_next            = 1'b0;
      green_next          = 1'b0;
      press_phase_next    = PH_IDLE;
      shutdown_count_next = '0;
    end

    job.status.pwm_duty       = duty_next;
    job.status.host_power     = powered_next || (shutdown_count_next != '0);
    job.status.panel_on       = panel_state_next;
    job.status.battery_select = !ac_ok_next && batt_ok_next;
    job.status.red_led        = red_next;
    job.status.green_led      = green_next;
    job.status.irq_pulse      = irq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ac_threshold   <= pseq_pkg::AC_THR_RESET;
      batt_threshold <= pseq_pkg::BATT_THR_RESET;
      hold_ticks     <= pseq_pkg::HOLD_RESET;
      shutdown_ticks <= pseq_pkg::SHDN_RESET;
    end else if (wr_en) begin
      case (wr_index)
        pseq_pkg::REG_AC_THR:   ac_threshold   <= wr_data[9:0];
        pseq_pkg::REG_BATT_THR: batt_threshold <= wr_data[9:0];
        pseq_pkg::REG_HOLD:     hold_ticks     <= wr_data[7:0];
        pseq_pkg::REG_SHDN:     shutdown_ticks <= wr_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      powered        <= 1'b0;
      panel_state    <= 1'b0;
      ac_ok          <= 1'b0;
      batt_ok        <= 1'b0;
      ac_sample      <= '0;
      batt_sample    <= '0;
      press_phase    <= PH_IDLE;
      hold_count     <= '0;
      shutdown_count <= '0;
      duty           <= pseq_pkg::DUTY_RESET;
      irq_seen       <= 1'b0;
      expect_duty    <= 1'b0;
      red            <= 1'b0;
      green          <= 1'b0;
    end else if (accept) begin
      powered        <= powered_next;
      panel_state    <= panel_state_next;
      ac_ok          <= ac_ok_next;
      batt_ok        <= batt_ok_next;
      ac_sample      <= ac_sample_next;
      batt_sample    <= batt_sample_next;
      press_phase    <= press_phase_next;
      hold_count     <= hold_count_next;
      shutdown_count <= shutdown_count_next;
      duty           <= duty_next;
      irq_seen       <= irq_seen_next;
      expect_duty    <= expect_duty_next;
      red            <= red_next;
      green          <= green_next;
    end
  end

endmodule

@@ hw/rtl/pseq_queue.sv @@
// pseq_queue: short job queue between front and back
// depends on pseq_pkg

module pseq_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pseq_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output pseq_pkg::job_t head
);

  pseq_pkg::job_t                   slots [pseq_pkg::QUEUE_DEPTH];
  logic [pseq_pkg::QPTR_BITS-1:0]   wr_ptr;
  logic [pseq_pkg::QPTR_BITS-1:0]   rd_ptr;
  logic [pseq_pkg::QPTR_BITS:0]     count;
  logic                             do_push;
  logic                             do_pop;

  assign full    = (count == (pseq_pkg::QPTR_BITS+1)'(pseq_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/pseq_back.sv @@
// pseq_back: expands queued jobs into result items and holds the output register
// a reading job gives three items: marked high bits, low byte, xor check
// depends on pseq_pkg

module pseq_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  pseq_pkg::job_t    q_head,
  output logic              q_pop,
  output logic              empty,
  input  logic              pop,
  output pseq_pkg::result_t result
);

  logic              out_valid;
  logic [1:0]        part;
  logic              advance;
  logic              last_part;
  pseq_pkg::result_t build;

  assign empty     = !out_valid;
  assign advance   = !out_valid || pop;
  assign last_part = (q_head.kind != pseq_pkg::JOB_TRIPLE) || (part == pseq_pkg::TRIPLE_LAST);
  assign q_pop     = advance && !q_empty && last_part;

  always_comb begin
    build.pwm_duty       = q_head.status.pwm_duty;
    build.host_power     = q_head.status.host_power;
    build.panel_on       = q_head.status.panel_on;
    build.battery_select = q_head.status.battery_select;
    build.red_led        = q_head.status.red_led;
    build.green_led      = q_head.status.green_led;
    build.irq_pulse      = q_head.status.irq_pulse;
    build.last           = last_part;
    case (q_head.kind)
      pseq_pkg::JOB_REPLY: begin
        build.reply_valid = 1'b1;
        build.reply_byte  = q_head.byte_hi;
      end
      pseq_pkg::JOB_TRIPLE: begin
        build.reply_valid = 1'b1;
        if (part == pseq_pkg::TRIPLE_LAST)     build.reply_byte = q_head.byte_hi ^ q_head.byte_lo;
        else if (part == pseq_pkg::TRIPLE_MID) build.reply_byte = q_head.byte_lo;
        else                                   build.reply_byte = q_head.byte_hi;
      end
      default: begin
        build.reply_valid = 1'b0;
        build.reply_byte  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      part      <= '0;
    end else if (advance) begin
      out_valid <= !q_empty;
      if (!q_empty) part <= last_part ? 2'd0 : part + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !q_empty) result <= build;
  end

endmodule

@@ hw/rtl/power_sequencer_with_spi_commands.sv @@
// power_sequencer_with_spi_commands: top level of the host power sequencer
// instantiates pseq_front, pseq_queue and pseq_back; types from pseq_pkg
//
//   channel   handshake            payload
//   input     push / full          item   (pseq_pkg::item_t)
//   result    empty / pop          result (pseq_pkg::result_t)
//   config    wr_en                wr_index, wr_data
//
// an item is classified and applied to the state in the cycle it is accepted;
// its results pass through the job queue and then the output register
// a tick or plain command gives one result and a reading gives three, one per cycle
// while pop keeps taking them, so the back end sets the pace of the output
// a four-entry job queue lets the input keep going while results stall on pop
// rst is synchronous; it restores register defaults and clears queue and output

module power_sequencer_with_spi_commands (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  pseq_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output pseq_pkg::result_t result,
  input  logic              wr_en,
  input  logic [1:0]        wr_index,
  input  logic [11:0]       wr_data
);

  pseq_pkg::job_t new_job;
  pseq_pkg::job_t head_job;
  logic           accept;
  logic           q_empty;
  logic           q_pop;

  assign accept = push && !full;

  pseq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .accept   (accept),
    .item     (item),
    .job      (new_job)
  );

  pseq_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_job (new_job),
    .full     (full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (head_job)
  );

  pseq_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (head_job),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

@@ hw/rtl/pseq_checker.sv @@
// pseq_checker: port-level checks for the power sequencer, bound to the top level
// depends on pseq_pkg

module pseq_checker (
  input logic              clk,
  input logic              rst,
  input logic              empty,
  input logic              pop,
  input pseq_pkg::result_t result
);

  // nothing left over from before reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed before pop");

  a_no_reply_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.reply_valid) |-> (result.reply_byte == '0))
    else $error("reply byte set without reply");

  // remaining parts of a reading follow without a gap
  a_triple_cont: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !result.last) |=> !empty)
    else $error("reading reply broken up");

  a_irq_panel: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.irq_pulse) |-> !result.panel_on)
    else $error("irq with panel still on");

endmodule

bind power_sequencer_with_spi_commands pseq_checker u_pseq_checker (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
